@@ src/pcba_pkg.sv @@
package pcba_pkg;

    // Operation codes of an input beat
    localparam logic [1:0] OP_LOAD_LIMIT = 2'd0;
    localparam logic [1:0] OP_LOAD_COUNT = 2'd1;
    localparam logic [1:0] OP_PEAK       = 2'd2;
    localparam logic [1:0] OP_READ       = 2'd3;

    // Configuration register indexes
    localparam logic CFG_USE_SUM_MODE = 1'b0;
    localparam logic CFG_GROUP_COUNT  = 1'b1;

    localparam int CFG_W = 3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GROUP,
        ST_FIRST,
        ST_CMP,
        ST_SRD,
        ST_SWR,
        ST_ADV,
        ST_RRD,
        ST_RWR
    } state_t;

    // Which limit row the limit memory reads
    typedef enum logic [1:0] {
        LROW_FIRST,
        LROW_SECOND,
        LROW_AFTER
    } lim_row_t;

    typedef struct packed {
        logic     load_limit;
        logic     load_count;
        logic     capture;
        logic     grp_next;
        logic     row_clear;
        logic     row_inc;
        lim_row_t lim_row;
        logic     lo_load;
        logic     cls_latch;
        logic     st_sel_read;
        logic     st_update;
        logic     out_load;
        logic     clr_step;
    } cmd_t;

    typedef struct packed {
        logic in_smp_ok;
        logic grp_done;
        logic cnt_zero;
        logic last_int;
        logic hit;
        logic cls_ok;
        logic sum_mode;
        logic clr_last;
    } sts_t;

endpackage

@@ src/pcba_ctrl.sv @@
module pcba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    output logic              out_valid,
    input  logic              out_ready,
    input  pcba_pkg::sts_t    sts,
    output pcba_pkg::cmd_t    cmd
);

    pcba_pkg::state_t state_reg;
    pcba_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_ready  = (state_reg == pcba_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcba_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = pcba_pkg::ST_IDLE;
                end
            end
            pcba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == pcba_pkg::OP_PEAK && sts.in_smp_ok)
                    begin
                        state_next = pcba_pkg::ST_GROUP;
                    end
                    else if (operation == pcba_pkg::OP_READ)
                    begin
                        state_next = pcba_pkg::ST_RRD;
                    end
                end
            end
            pcba_pkg::ST_GROUP:
            begin
                if (sts.grp_done)
                begin
                    state_next = pcba_pkg::ST_IDLE;
                end
                else if (!sts.cnt_zero)
                begin
                    state_next = pcba_pkg::ST_FIRST;
                end
            end
            pcba_pkg::ST_FIRST:
            begin
                state_next = pcba_pkg::ST_CMP;
            end
            pcba_pkg::ST_CMP:
            begin
                if (sts.hit && sts.sum_mode)
                begin
                    state_next = sts.cls_ok ? pcba_pkg::ST_SRD : pcba_pkg::ST_IDLE;
                end
                else if (sts.hit && sts.cls_ok)
                begin
                    state_next = pcba_pkg::ST_SRD;
                end
                else if (sts.last_int)
                begin
                    state_next = pcba_pkg::ST_GROUP;
                end
            end
            pcba_pkg::ST_SRD:
            begin
                state_next = pcba_pkg::ST_SWR;
            end
            pcba_pkg::ST_SWR:
            begin
                state_next = sts.sum_mode ? pcba_pkg::ST_IDLE : pcba_pkg::ST_ADV;
            end
            pcba_pkg::ST_ADV:
            begin
                state_next = sts.last_int ? pcba_pkg::ST_GROUP : pcba_pkg::ST_CMP;
            end
            pcba_pkg::ST_RRD:
            begin
                state_next = pcba_pkg::ST_RWR;
            end
            pcba_pkg::ST_RWR:
            begin
                if (out_free)
                begin
                    state_next = pcba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.lim_row = pcba_pkg::LROW_FIRST;
        case (state_reg)
            pcba_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            pcba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        pcba_pkg::OP_LOAD_LIMIT: cmd.load_limit = 1'b1;
                        pcba_pkg::OP_LOAD_COUNT: cmd.load_count = 1'b1;
                        default:                 cmd.capture    = 1'b1;
                    endcase
                end
            end
            pcba_pkg::ST_GROUP:
            begin
                if (!sts.grp_done)
                begin
                    if (sts.cnt_zero)
                    begin
                        cmd.grp_next = 1'b1;
                    end
                    else
                    begin
                        cmd.row_clear = 1'b1;
                        cmd.lim_row   = pcba_pkg::LROW_FIRST;
                    end
                end
            end
            pcba_pkg::ST_FIRST:
            begin
                cmd.lo_load = 1'b1;
                cmd.lim_row = pcba_pkg::LROW_SECOND;
            end
            pcba_pkg::ST_CMP:
            begin
                cmd.lo_load   = 1'b1;
                cmd.cls_latch = 1'b1;
                // advance unless this interval goes to the store or, in sum mode, a hit ends the scan
                if (!(sts.hit && (sts.sum_mode || sts.cls_ok)))
                begin
                    if (sts.last_int)
                    begin
                        cmd.grp_next = 1'b1;
                    end
                    else
                    begin
                        cmd.row_inc = 1'b1;
                        cmd.lim_row = pcba_pkg::LROW_AFTER;
                    end
                end
            end
            pcba_pkg::ST_SWR:
            begin
                cmd.st_update = 1'b1;
            end
            pcba_pkg::ST_ADV:
            begin
                if (sts.last_int)
                begin
                    cmd.grp_next = 1'b1;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    cmd.lim_row = pcba_pkg::LROW_AFTER;
                end
            end
            pcba_pkg::ST_RRD:
            begin
                cmd.st_sel_read = 1'b1;
            end
            pcba_pkg::ST_RWR:
            begin
                cmd.st_sel_read = 1'b1;
                cmd.out_load    = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcba_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/pcba_dpath.sv @@
module pcba_dpath #(
    parameter int GROUPS     = 4,
    parameter int LIMIT_ROWS = 16,
    parameter int SAMPLES    = 16,
    parameter int CLASSES    = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_enable,
    input  logic                       cfg_index,
    input  logic [pcba_pkg::CFG_W-1:0] cfg_data,
    input  logic [1:0]                 group,
    input  logic [3:0]                 limit_index,
    input  logic signed [31:0]         limit_value,
    input  logic [3:0]                 class_count,
    input  logic signed [31:0]         position,
    input  logic signed [31:0]         height,
    input  logic [3:0]                 sample,
    input  logic [5:0]                 class_index,
    input  pcba_pkg::cmd_t             cmd,
    output pcba_pkg::sts_t             sts,
    output logic signed [31:0]         accumulated_value
);

    localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int GCNT_W = $clog2(GROUPS + 1);
    localparam int GEXT_W = $clog2(GROUPS + 1) + 3;
    localparam int ROW_W  = $clog2(LIMIT_ROWS);
    localparam int RN_W   = ROW_W + 1;
    localparam int LEXT_W = $clog2(LIMIT_ROWS + 1) + 4;
    localparam int CEW    = ROW_W + 5;
    localparam int LDEPTH = LIMIT_ROWS * GROUPS;
    localparam int LA_W   = $clog2(LDEPTH);
    localparam int SDEPTH = SAMPLES * CLASSES;
    localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int BASE_W = $clog2(GROUPS * 16 + LIMIT_ROWS + CLASSES + 1);
    localparam int SEXT_W = $clog2(SAMPLES + 1) + 4;
    localparam int CXT_W  = $clog2(CLASSES + 1) + 6;

    logic signed [31:0] lim_mem [LDEPTH];
    logic signed [31:0] st_mem  [SDEPTH];
    logic [3:0]         cnt_reg [GROUPS];

    logic                  sum_mode_reg;
    logic [2:0]            group_count_reg;
    logic signed [31:0]    pos_reg;
    logic signed [31:0]    height_reg;
    logic [3:0]            sample_reg;
    logic [5:0]            cidx_reg;
    logic [GCNT_W-1:0]     g_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [BASE_W-1:0]     base_reg;
    logic [BASE_W-1:0]     cls_reg;
    logic signed [31:0]    lo_reg;
    logic signed [31:0]    lim_rd_reg;
    logic signed [31:0]    st_rd_reg;
    logic signed [31:0]    out_data_reg;
    logic [SA_W-1:0]       clr_reg;

    logic [GEXT_W-1:0]     grp_ext;
    logic [LEXT_W-1:0]     lidx_ext;
    logic [LA_W-1:0]       lim_wr_addr;
    logic [RN_W-1:0]       rd_row;
    logic [LA_W-1:0]       lim_rd_addr;
    logic [3:0]            cur_cnt;
    logic [ROW_W-1:0]      n_cap;
    logic [GEXT_W-1:0]     gc_ext;
    logic [GEXT_W-1:0]     ng_ext;
    logic [BASE_W-1:0]     cls_cur;
    logic                  rd_ok;
    logic [SA_W-1:0]       peak_addr;
    logic [SA_W-1:0]       read_addr;
    logic [SA_W-1:0]       st_rd_addr;
    logic                  st_we;
    logic [SA_W-1:0]       st_wa;
    logic signed [31:0]    st_wd;
    logic [32:0]           sum33;
    logic signed [31:0]    sat_sum;

    // ---------------- table loads ----------------
    assign grp_ext     = GEXT_W'(group);
    assign lidx_ext    = LEXT_W'(limit_index);
    assign lim_wr_addr = LA_W'(int'(limit_index) * GROUPS + int'(group));

    always_ff @(posedge clk)
    begin
        if (cmd.load_limit && grp_ext < GEXT_W'(GROUPS) && lidx_ext < LEXT_W'(LIMIT_ROWS))
        begin
            lim_mem[lim_wr_addr] <= limit_value;
        end
        lim_rd_reg <= lim_mem[lim_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < GROUPS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (cmd.load_count && grp_ext < GEXT_W'(GROUPS))
        begin
            cnt_reg[grp_ext[GIDX_W-1:0]] <= class_count;
        end
    end

    // ---------------- config ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_mode_reg    <= 1'b1;
            group_count_reg <= 3'd1;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                pcba_pkg::CFG_USE_SUM_MODE: sum_mode_reg    <= cfg_data[0];
                pcba_pkg::CFG_GROUP_COUNT:  group_count_reg <= cfg_data[2:0];
                default:                    sum_mode_reg    <= sum_mode_reg;
            endcase
        end
    end

    // ---------------- interval scan ----------------
    always_comb
    begin
        case (cmd.lim_row)
            pcba_pkg::LROW_FIRST:  rd_row = '0;
            pcba_pkg::LROW_SECOND: rd_row = RN_W'(1);
            pcba_pkg::LROW_AFTER:  rd_row = RN_W'(row_reg) + RN_W'(2);
            default:               rd_row = '0;
        endcase
    end

    assign lim_rd_addr = LA_W'(int'(rd_row) * GROUPS + int'(g_reg));
    assign cur_cnt     = cnt_reg[g_reg[GIDX_W-1:0]];
    assign n_cap       = (CEW'(cur_cnt) > CEW'(LIMIT_ROWS - 1)) ? ROW_W'(LIMIT_ROWS - 1)
                                                                : ROW_W'(cur_cnt);
    assign gc_ext      = GEXT_W'(group_count_reg);
    assign ng_ext      = (gc_ext < GEXT_W'(GROUPS)) ? gc_ext : GEXT_W'(GROUPS);
    assign cls_cur     = base_reg + BASE_W'(row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg    <= '0;
            row_reg  <= '0;
            base_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                g_reg    <= '0;
                base_reg <= '0;
            end
            else if (cmd.grp_next)
            begin
                g_reg    <= g_reg + GCNT_W'(1);
                // base moves by the loaded count, not the capped one
                base_reg <= base_reg + BASE_W'(cur_cnt);
            end
            if (cmd.row_clear)
            begin
                row_reg <= '0;
            end
            else if (cmd.row_inc)
            begin
                row_reg <= row_reg + ROW_W'(1);
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + SA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg    <= position;
            height_reg <= height;
            sample_reg <= sample;
            cidx_reg   <= class_index;
        end
        if (cmd.lo_load)
        begin
            lo_reg <= lim_rd_reg;
        end
        if (cmd.cls_latch)
        begin
            cls_reg <= cls_cur;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= rd_ok ? st_rd_reg : '0;
        end
    end

    // ---------------- height store ----------------
    assign rd_ok      = (SEXT_W'(sample_reg) < SEXT_W'(SAMPLES))
                     && (CXT_W'(cidx_reg) < CXT_W'(CLASSES));
    assign peak_addr  = SA_W'(int'(sample_reg) * CLASSES + int'(cls_reg));
    assign read_addr  = SA_W'(int'(sample_reg) * CLASSES + int'(cidx_reg));
    assign st_rd_addr = cmd.st_sel_read ? read_addr : peak_addr;

    assign sum33   = {st_rd_reg[31], st_rd_reg} + {height_reg[31], height_reg};
    assign sat_sum = (sum33[32] != sum33[31]) ? (sum33[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}})
                                              : sum33[31:0];

    always_comb
    begin
        st_we = 1'b0;
        st_wa = clr_reg;
        st_wd = '0;
        if (cmd.clr_step)
        begin
            st_we = 1'b1;
        end
        else if (cmd.st_update)
        begin
            st_wa = peak_addr;
            st_wd = sum_mode_reg ? sat_sum : height_reg;
            st_we = sum_mode_reg || (st_rd_reg < height_reg);
        end
        else if (cmd.out_load)
        begin
            st_wa = read_addr;
            st_we = rd_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
        st_rd_reg <= st_mem[st_rd_addr];
    end

    // ---------------- status ----------------
    assign sts.in_smp_ok = SEXT_W'(sample) < SEXT_W'(SAMPLES);
    assign sts.grp_done  = GEXT_W'(g_reg) >= ng_ext;
    assign sts.cnt_zero  = (n_cap == '0);
    assign sts.last_int  = (RN_W'(row_reg) + RN_W'(1)) == RN_W'(n_cap);
    assign sts.hit       = (lo_reg <= pos_reg) && (pos_reg < lim_rd_reg);
    assign sts.cls_ok    = cls_cur < BASE_W'(CLASSES);
    assign sts.sum_mode  = sum_mode_reg;
    assign sts.clr_last  = (clr_reg == SA_W'(SDEPTH - 1));

    assign accumulated_value = out_data_reg;

endmodule

@@ src/peak_class_binning_accumulator_core.sv @@
// A load updates its table as its beat is accepted. A read passes a store read state and then a
// write-back state that loads the output register. A peak walks each group in use, skipping one
// with no classes, else scanning one row per cycle up to the capped class count; a store update
// (a read and a write state) pauses the scan, ends it in sum mode, and adds an advance state in max
// mode. One beat is worked at a time; a read waits in place while the previous result is unread.
// Reset: asynchronous, active low; then a clearing pass zeroes the store.
module peak_class_binning_accumulator_core #(
    parameter int GROUPS     = 4,
    parameter int LIMIT_ROWS = 16,
    parameter int SAMPLES    = 16,
    parameter int CLASSES    = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write port (index 0: use_sum_mode, index 1: group_count)
    input  logic                       cfg_write_enable,
    input  logic                       cfg_index,
    input  logic [pcba_pkg::CFG_W-1:0] cfg_data,
    // input beat
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 operation,
    input  logic [1:0]                 group,
    input  logic [3:0]                 limit_index,
    input  logic signed [31:0]         limit_value,
    input  logic [3:0]                 class_count,
    input  logic signed [31:0]         position,
    input  logic signed [31:0]         height,
    input  logic [3:0]                 sample,
    input  logic [5:0]                 class_index,
    // result beat (read operations only)
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [31:0]         accumulated_value
);

    // The controller sequences the clearing pass, the group/interval scan of a
    // peak and the read-modify-write of one store entry. The datapath holds the
    // limit memory, the class-count registers, the height store and the output
    // register that decouples a finished read from the next input beat.
    pcba_pkg::cmd_t cmd;
    pcba_pkg::sts_t sts;

    pcba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pcba_dpath #(
        .GROUPS     (GROUPS),
        .LIMIT_ROWS (LIMIT_ROWS),
        .SAMPLES    (SAMPLES),
        .CLASSES    (CLASSES)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_enable  (cfg_write_enable),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .group             (group),
        .limit_index       (limit_index),
        .limit_value       (limit_value),
        .class_count       (class_count),
        .position          (position),
        .height            (height),
        .sample            (sample),
        .class_index       (class_index),
        .cmd               (cmd),
        .sts               (sts),
        .accumulated_value (accumulated_value)
    );

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Block sizes, kept at the defaults of the core
    localparam int GROUPS     = 4;
    localparam int LIMIT_ROWS = 16;
    localparam int SAMPLES    = 16;
    localparam int CLASSES    = 64;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    // Slowest peak: full scan of 4 x 15 intervals plus a store update for every
    // overlapping match in max mode; the settle wait covers any tail.
    localparam int SETTLE_CYCLES  = 300;
    localparam int DRAIN_GUARD    = 50_000;
    localparam int TIMEOUT_CYCLES = 3_000_000;

    localparam int INT_MAX = 32'sh7fff_ffff;
    localparam int INT_MIN = 32'sh8000_0000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One input beat, all fields carried whatever the operation
    typedef struct {
        logic [1:0] op;
        logic [1:0] grp;
        logic [3:0] row;
        int         lim;
        logic [3:0] cnt;
        int         pos;
        int         height;
        logic [3:0] smp;
        logic [5:0] cls;
    } beat_t;

    // Directed row: a beat plus an optional hand-written expected value
    typedef struct {
        beat_t b;
        bit    typed;
        int    want;
    } directed_row_t;

    logic                       clk              = 1'b0;
    logic                       rst_n            = 1'b0;
    logic                       cfg_write_enable = 1'b0;
    logic                       cfg_index        = pcba_pkg::CFG_USE_SUM_MODE;
    logic [pcba_pkg::CFG_W-1:0] cfg_data         = '0;
    logic                       in_valid         = 1'b0;
    logic                       in_ready;
    logic [1:0]                 operation        = pcba_pkg::OP_READ;
    logic [1:0]                 group            = '0;
    logic [3:0]                 limit_index      = '0;
    logic signed [31:0]         limit_value      = '0;
    logic [3:0]                 class_count      = '0;
    logic signed [31:0]         position         = '0;
    logic signed [31:0]         height           = '0;
    logic [3:0]                 sample           = '0;
    logic [5:0]                 class_index      = '0;
    logic                       out_valid;
    logic                       out_ready        = 1'b0;
    logic signed [31:0]         accumulated_value;

    // Predictor state: limit table with a written mark per row, class counts,
    // per-sample bins and the two configuration registers
    int         limit_mem     [LIMIT_ROWS*GROUPS];
    bit         limit_written [LIMIT_ROWS*GROUPS];
    logic [3:0] count_mem     [GROUPS];
    int         bin_store     [SAMPLES*CLASSES];
    bit         sum_mode      = 1'b1;
    logic [2:0] groups_in_use = 3'd1;

    int expected_entry_values[$];
    int error_count = 0;
    int beats_sent  = 0;

    // Shared between the stimulus thread and the receiver process
    idle_mode_t idle_mode = IDLE_NONE;
    int         hold_left = 0;

    directed_row_t directed_rows[$];

    peak_class_binning_accumulator_core #(
        .GROUPS    (GROUPS),
        .LIMIT_ROWS(LIMIT_ROWS),
        .SAMPLES   (SAMPLES),
        .CLASSES   (CLASSES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .group            (group),
        .limit_index      (limit_index),
        .limit_value      (limit_value),
        .class_count      (class_count),
        .position         (position),
        .height           (height),
        .sample           (sample),
        .class_index      (class_index),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accumulated_value(accumulated_value)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string line);
        $display("ERROR @%0t: %s", $time, line);
        error_count++;
    endtask

    function automatic int active_groups();
        return (groups_in_use < GROUPS) ? int'(groups_in_use) : GROUPS;
    endfunction

    // Counts above LIMIT_ROWS-1 are clamped when scanning (not for the flat base)
    function automatic int capped_count(input int g);
        return (count_mem[g] > LIMIT_ROWS - 1) ? LIMIT_ROWS - 1 : int'(count_mem[g]);
    endfunction

    // Predictor: applies one accepted beat and returns the read value, if any
    function automatic void accumulate_beat(input beat_t b, output bit produces,
                                            output int value);
        int     base;
        int     lo;
        int     hi;
        int     flat;
        int     addr;
        longint total;
        produces = 1'b0;
        value    = 0;
        case (b.op)
            pcba_pkg::OP_LOAD_LIMIT:
            begin
                limit_mem[int'(b.row)*GROUPS + int'(b.grp)]     = b.lim;
                limit_written[int'(b.row)*GROUPS + int'(b.grp)] = 1'b1;
            end
            pcba_pkg::OP_LOAD_COUNT:
            begin
                count_mem[b.grp] = b.cnt;
            end
            pcba_pkg::OP_PEAK:
            begin
                base = 0;
                for (int g = 0; g < active_groups(); g++)
                begin
                    for (int i = 0; i < capped_count(g); i++)
                    begin
                        lo   = limit_mem[i*GROUPS + g];
                        hi   = limit_mem[(i+1)*GROUPS + g];
                        flat = base + i;
                        addr = int'(b.smp)*CLASSES + flat;
                        if (lo <= b.pos && b.pos < hi)
                        begin
                            if (sum_mode)
                            begin
                                // first hit wins; sum saturates at the 32-bit limits
                                if (flat < CLASSES)
                                begin
                                    total = longint'(bin_store[addr]) + longint'(b.height);
                                    if (total > INT_MAX)
                                        total = INT_MAX;
                                    else if (total < INT_MIN)
                                        total = INT_MIN;
                                    bin_store[addr] = int'(total);
                                end
                                return;
                            end
                            if (flat < CLASSES && bin_store[addr] < b.height)
                                bin_store[addr] = b.height;
                        end
                    end
                    base += int'(count_mem[g]);
                end
            end
            default:
            begin
                produces = 1'b1;
                if (b.smp < SAMPLES && b.cls < CLASSES)
                begin
                    addr            = int'(b.smp)*CLASSES + int'(b.cls);
                    value           = bin_store[addr];
                    bin_store[addr] = 0;
                end
            end
        endcase
    endfunction

    function automatic beat_t make_beat(input logic [1:0] op, input logic [1:0] grp,
                                        input logic [3:0] row, input int lim,
                                        input logic [3:0] cnt, input int pos,
                                        input int hgt, input logic [3:0] smp,
                                        input logic [5:0] cls);
        beat_t b;
        b.op = op; b.grp = grp; b.row = row; b.lim = lim; b.cnt = cnt;
        b.pos = pos; b.height = hgt; b.smp = smp; b.cls = cls;
        return b;
    endfunction

    // All fields random; callers override the ones the operation uses
    function automatic beat_t random_fields();
        return make_beat(pcba_pkg::OP_READ, 2'($urandom_range(0, 3)),
                         4'($urandom_range(0, 15)), int'($urandom),
                         4'($urandom_range(0, 15)), int'($urandom),
                         int'($urandom), 4'($urandom_range(0, 15)),
                         6'($urandom_range(0, 63)));
    endfunction

    // Most beats hit the first few samples so reads find something
    function automatic logic [3:0] pick_sample();
        return ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 3))
                                           : 4'($urandom_range(0, 15));
    endfunction

    // First group in use whose scanned rows are not all loaded, or -1
    function automatic int first_unwritten_group();
        for (int g = 0; g < active_groups(); g++)
        begin
            if (capped_count(g) > 0)
            begin
                for (int r = 0; r <= capped_count(g); r++)
                begin
                    if (!limit_written[r*GROUPS + g])
                        return g;
                end
            end
        end
        return -1;
    endfunction

    // Drive one beat at a falling edge, hold it until accepted, then predict.
    // Returns at the falling edge after acceptance with valid still high.
    task automatic send_beat(input beat_t b, input bit typed, input int want);
        int idle_pct;
        bit produces;
        int value;
        idle_pct = (idle_mode == IDLE_SENDER) ? 85 : (idle_mode == IDLE_BOTH) ? 22 : 0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= b.op;
        group       <= b.grp;
        limit_index <= b.row;
        limit_value <= b.lim;
        class_count <= b.cnt;
        position    <= b.pos;
        height      <= b.height;
        sample      <= b.smp;
        class_index <= b.cls;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_beat(b, produces, value);
        if (produces)
            expected_entry_values.push_back(typed ? want : value);
        beats_sent++;
        @(negedge clk);
    endtask

    // Well-formed table for one group: strictly rising limits, then its class count
    task automatic load_sorted_table(input int g);
        int     n;
        int     step_max;
        longint bound;
        beat_t  b;
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, LIMIT_ROWS - 1);
        case ($urandom_range(0, 2))
            0:
            begin
                bound    = longint'($urandom_range(0, 40)) - 20;
                step_max = 4;
            end
            1:
            begin
                bound    = longint'($urandom_range(0, 100_000)) - 50_000;
                step_max = 5000;
            end
            default:
            begin
                bound    = ($urandom_range(0, 1) == 1) ? longint'(INT_MIN) : -(64'sd1 <<< 30);
                step_max = 1 << 26;
            end
        endcase
        if (n > 0)
        begin
            for (int r = 0; r <= n; r++)
            begin
                b     = random_fields();
                b.op  = pcba_pkg::OP_LOAD_LIMIT;
                b.grp = 2'(g);
                b.row = 4'(r);
                b.lim = int'(bound);
                send_beat(b, 1'b0, 0);
                bound += longint'($urandom_range(1, step_max));
            end
        end
        b     = random_fields();
        b.op  = pcba_pkg::OP_LOAD_COUNT;
        b.grp = 2'(g);
        b.cnt = 4'(n);
        send_beat(b, 1'b0, 0);
    endtask

    // Peak aimed mostly inside a loaded interval; the scanned rows of every
    // group in use are loaded first so no peak touches an unwritten limit
    task automatic send_peak();
        beat_t  b;
        int     bad;
        int     g;
        int     i;
        int     lo;
        int     hi;
        longint span;
        bad = first_unwritten_group();
        while (bad >= 0)
        begin
            load_sorted_table(bad);
            bad = first_unwritten_group();
        end
        b     = random_fields();
        b.op  = pcba_pkg::OP_PEAK;
        b.smp = pick_sample();
        case ($urandom_range(0, 9))
            0:       b.height = ($urandom_range(0, 1) == 1) ? INT_MAX : INT_MIN;
            1, 2:    ;  // full random height
            default: b.height = int'($urandom_range(0, 1 << 20)) - (1 << 18);
        endcase
        if ($urandom_range(0, 19) == 0)
            b.pos = ($urandom_range(0, 1) == 1) ? INT_MAX : INT_MIN;
        else if (active_groups() > 0 && $urandom_range(0, 99) < 80)
        begin
            g = $urandom_range(0, active_groups() - 1);
            if (capped_count(g) > 0)
            begin
                i  = $urandom_range(0, capped_count(g) - 1);
                lo = limit_mem[i*GROUPS + g];
                hi = limit_mem[(i+1)*GROUPS + g];
                // bounds exactly: lower is inside, upper belongs to the next interval
                if ($urandom_range(0, 7) == 0)
                    b.pos = ($urandom_range(0, 1) == 1) ? hi : lo;
                else if (lo < hi)
                begin
                    span  = longint'(hi) - longint'(lo);
                    b.pos = int'(longint'(lo) + (longint'($urandom) % span));
                end
            end
        end
        send_beat(b, 1'b0, 0);
    endtask

    task automatic send_read();
        beat_t b;
        int    total;
        b     = random_fields();
        b.op  = pcba_pkg::OP_READ;
        b.smp = pick_sample();
        total = 0;
        for (int g = 0; g < active_groups(); g++)
            total += int'(count_mem[g]);
        if (total > CLASSES)
            total = CLASSES;
        if (total > 0 && $urandom_range(0, 99) < 70)
            b.cls = 6'($urandom_range(0, total - 1));
        send_beat(b, 1'b0, 0);
    endtask

    // Drop valid, wait out every pending read, then let any trailing peak finish.
    // Leaves the thread at a falling edge.
    task automatic drain_block();
        int guard;
        guard    = 0;
        in_valid <= 1'b0;
        while (expected_entry_values.size() > 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_entry_values.size() > 0)
        begin
            report_mismatch($sformatf("%0d reads never answered",
                                      expected_entry_values.size()));
            expected_entry_values.delete();
        end
        @(negedge clk);
    endtask

    // One random phase: registers written while idle, then a mix of table
    // reloads, stray loads, peaks and reads, then a full drain
    task automatic run_phase(input bit mode, input logic [2:0] gc, input idle_mode_t m,
                             input int beats, input int hold);
        logic [1:0] filler;
        int         target;
        beat_t      b;
        int         pick;
        // only bit 0 of the mode write matters; upper bits are junk on purpose
        filler           = 2'($urandom_range(0, 3));
        cfg_write_enable <= 1'b1;
        cfg_index        <= pcba_pkg::CFG_USE_SUM_MODE;
        cfg_data         <= {filler, mode};
        sum_mode         = mode;
        @(negedge clk);
        cfg_index        <= pcba_pkg::CFG_GROUP_COUNT;
        cfg_data         <= gc;
        groups_in_use    = gc;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        @(negedge clk);

        idle_mode = m;
        hold_left = hold;
        target    = beats_sent + beats;
        while (beats_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                load_sorted_table($urandom_range(0, GROUPS - 1));
            else if (pick < 9)
            begin
                // stray limit write, may leave a group unsorted
                b    = random_fields();
                b.op = pcba_pkg::OP_LOAD_LIMIT;
                send_beat(b, 1'b0, 0);
            end
            else if (pick < 13)
            begin
                b    = random_fields();
                b.op = pcba_pkg::OP_LOAD_COUNT;
                send_beat(b, 1'b0, 0);
            end
            else if (pick < 62)
                send_peak();
            else
                send_read();
        end
        drain_block();
    endtask

    // Result checker: every read beat compared with the oldest prediction
    always @(posedge clk)
    begin
        int want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_entry_values.size() == 0)
                report_mismatch($sformatf("unexpected result %h", accumulated_value));
            else
            begin
                want = expected_entry_values.pop_front();
                if (accumulated_value !== want)
                    report_mismatch($sformatf("accumulated_value %h, expected %h",
                                              accumulated_value, want));
            end
        end
    end

    // Receiver: long hold-off when asked (fills the block so it stalls its
    // input), otherwise ready follows the current stall pattern
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (idle_mode)
                IDLE_RECEIVER: out_ready <= ($urandom_range(0, 99) >= 85);
                IDLE_BOTH:     out_ready <= ($urandom_range(0, 99) >= 22);
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        foreach (limit_mem[k])
        begin
            limit_mem[k]     = 0;
            limit_written[k] = 1'b0;
        end
        foreach (count_mem[k])
            count_mem[k] = '0;
        foreach (bin_store[k])
            bin_store[k] = 0;

        // Directed part, reset defaults: sum mode, one group.
        // Group 0 intervals: [MIN,-1000) [-1000,0) [0,1000) [1000,MAX)
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 15, 63),
                                  1'b1, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_LIMIT, 0, 0, INT_MIN, 0, 0,
                                            0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_LIMIT, 0, 1, -1000, 0, 0,
                                            0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_LIMIT, 0, 2, 0, 0, 0,
                                            0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_LIMIT, 0, 3, 1000, 0, 0,
                                            0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_LIMIT, 0, 4, INT_MAX, 0, 0,
                                            0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_COUNT, 0, 0, 0, 4, 0,
                                            0, 0, 0), 1'b0, 0});
        // positive saturation in class 0
        directed_rows.push_back('{make_beat(pcba_pkg::OP_PEAK, 0, 0, 0, 0, INT_MIN,
                                            INT_MAX, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_PEAK, 0, 0, 0, 0, -2000,
                                            INT_MAX, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, INT_MAX});
        // read clears the entry
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, 0});
        // negative saturation in class 2
        directed_rows.push_back('{make_beat(pcba_pkg::OP_PEAK, 0, 0, 0, 0, 0,
                                            INT_MIN, 15, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_PEAK, 0, 0, 0, 0, 999,
                                            INT_MIN, 15, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 15, 2),
                                  1'b1, INT_MIN});
        // upper bound is exclusive: MAX matches nothing
        directed_rows.push_back('{make_beat(pcba_pkg::OP_PEAK, 0, 0, 0, 0, INT_MAX,
                                            5, 3, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 3, 3),
                                  1'b1, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_PEAK, 0, 0, 0, 0, 1000,
                                            -7, 3, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 3, 3),
                                  1'b0, 0});
        // other groups: not scanned with one group in use
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_LIMIT, 3, 15, 32'sh5555_5555,
                                            0, 0, 0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_COUNT, 3, 0, 0, 15, 0,
                                            0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_LOAD_COUNT, 1, 0, 0, 0, 0,
                                            0, 0, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_PEAK, 0, 0, 0, 0, -1,
                                            32'sh0001_8000, 1, 0), 1'b0, 0});
        directed_rows.push_back('{make_beat(pcba_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1, 1),
                                  1'b0, 0});

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // in_ready stays low through the post-reset clearing pass
        foreach (directed_rows[k])
            send_beat(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].want);
        drain_block();

        // Random phases: both modes, group counts from none to beyond the table
        run_phase(1'b1, 3'd1, IDLE_NONE,     150, 0);
        run_phase(1'b0, 3'd4, IDLE_SENDER,   200, 0);
        run_phase(1'b1, 3'd4, IDLE_RECEIVER, 200, 0);
        run_phase(1'b0, 3'd7, IDLE_BOTH,     200, 0);
        run_phase(1'b1, 3'd0, IDLE_NONE,     100, 0);
        run_phase(1'b0, 3'd2, IDLE_NONE,     150, 600);
        run_phase(1'b1, 3'd3, IDLE_BOTH,     380, 0);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
